/* hdl/scbpa_pkg.sv */
package scbpa_pkg;

    localparam int BLOCKS_PER_CLASS = 256;
    localparam int REF_BITS         = 8;

    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int LIMIT_W     = 16;
    localparam int SIZE_W      = 32;
    localparam int IN_IDX_W    = 8;
    localparam int OUT_CNT_W   = 8;
    localparam int ST_W        = 3;

    // Block number within a class, and a link that can also hold the empty mark.
    localparam int IDX_W     = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
    localparam int NEXT_W    = IDX_W + 1;
    localparam int SLOT_W    = CLS_W + IDX_W;
    localparam int MEM_DEPTH = NUM_CLASSES << IDX_W;

    localparam logic [NEXT_W-1:0]   EMPTY_MARK = NEXT_W'(BLOCKS_PER_CLASS);
    localparam logic [REF_BITS-1:0] REF_MAX    = '1;

    localparam logic [LIMIT_W-1:0] LIMIT0_RST = 16'd64;
    localparam logic [LIMIT_W-1:0] LIMIT1_RST = 16'd128;
    localparam logic [LIMIT_W-1:0] LIMIT2_RST = 16'd512;
    localparam logic [LIMIT_W-1:0] LIMIT3_RST = 16'd1024;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_ADDREF = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_SATURATED = 3'd4
    } t_status;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_stat;

endpackage

/* hdl/scbpa_ctrl.sv */
module scbpa_ctrl
    import scbpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.clear_en = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.exec     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* hdl/scbpa_dp.sv */
module scbpa_dp
    import scbpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CLS_W-1:0]     i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    input  logic [1:0]           i_req_type,
    input  logic [SIZE_W-1:0]    i_request_size,
    input  logic [CLS_W-1:0]     i_block_class,
    input  logic [IN_IDX_W-1:0]  i_block_index,
    output logic                 o_done,
    output logic [ST_W-1:0]      o_status,
    output logic [CLS_W-1:0]     o_granted_class,
    output logic [IN_IDX_W-1:0]  o_granted_index,
    output logic [OUT_CNT_W-1:0] o_ref_count
);

    logic [LIMIT_W-1:0] r_limit [NUM_CLASSES];
    logic [NEXT_W-1:0]  r_free_head [NUM_CLASSES];
    logic [SLOT_W-1:0]  r_sweep;
    logic               r_done;

    logic [NEXT_W-1:0]   r_next_free [MEM_DEPTH];
    logic [REF_BITS-1:0] r_ref_counts [MEM_DEPTH];
    logic [NEXT_W-1:0]   r_nf_rd;
    logic [REF_BITS-1:0] r_rc_rd;

    t_req               r_kind;
    logic [CLS_W-1:0]   r_cls;
    logic [IDX_W-1:0]   r_idx;
    logic [IN_IDX_W-1:0] r_in_idx;
    logic               r_oob;
    logic               r_too_large;
    logic [NEXT_W-1:0]  r_head;
    logic [SLOT_W-1:0]  r_slot;

    logic [ST_W-1:0]      r_status;
    logic [CLS_W-1:0]     r_granted_class;
    logic [IN_IDX_W-1:0]  r_granted_index;
    logic [OUT_CNT_W-1:0] r_ref_count;

    logic [CLS_W-1:0]  alloc_cls;
    logic              too_large;
    logic [CLS_W-1:0]  head_sel;
    logic [NEXT_W-1:0] head_rd;
    logic [IDX_W-1:0]  in_blk;
    logic              in_oob;
    logic [CLS_W-1:0]  rd_cls;
    logic [IDX_W-1:0]  rd_blk;
    logic [SLOT_W-1:0] rd_addr;

    logic [IDX_W-1:0]  sweep_blk;
    logic [NEXT_W-1:0] sweep_link;

    logic                nf_we;
    logic [NEXT_W-1:0]   nf_wd;
    logic                rc_we;
    logic [REF_BITS-1:0] rc_wd;
    logic [SLOT_W-1:0]   mem_waddr;
    logic                head_we;
    logic [NEXT_W-1:0]   head_wd;

    logic [ST_W-1:0]      n_status;
    logic [CLS_W-1:0]     n_granted_class;
    logic [IN_IDX_W-1:0]  n_granted_index;
    logic [OUT_CNT_W-1:0] n_ref_count;
    logic [REF_BITS-1:0]  cnt_dec;
    logic [REF_BITS-1:0]  cnt_inc;

    // Smallest class whose limit covers the size, tested in class order.
    always_comb begin
        too_large = 1'b0;
        alloc_cls = CLS_W'(0);
        if (i_request_size <= SIZE_W'(r_limit[0])) begin
            alloc_cls = CLS_W'(0);
        end else if (i_request_size <= SIZE_W'(r_limit[1])) begin
            alloc_cls = CLS_W'(1);
        end else if (i_request_size <= SIZE_W'(r_limit[2])) begin
            alloc_cls = CLS_W'(2);
        end else if (i_request_size <= SIZE_W'(r_limit[3])) begin
            alloc_cls = CLS_W'(3);
        end else begin
            too_large = 1'b1;
        end
    end

    // The head registers have one read port, shared between accept and write-back.
    assign head_sel = i_cmd.exec ? r_cls : alloc_cls;
    assign head_rd  = r_free_head[head_sel];

    assign in_blk  = IDX_W'(i_block_index);
    assign in_oob  = (32'(i_block_index) >= 32'(BLOCKS_PER_CLASS));
    assign rd_cls  = (t_req'(i_req_type) == REQ_ALLOC) ? alloc_cls : i_block_class;
    assign rd_blk  = (t_req'(i_req_type) == REQ_ALLOC) ? head_rd[IDX_W-1:0] : in_blk;
    assign rd_addr = {rd_cls, rd_blk};

    assign sweep_blk  = r_sweep[IDX_W-1:0];
    assign sweep_link = ((NEXT_W'(sweep_blk) + NEXT_W'(1)) < EMPTY_MARK) ?
                        (NEXT_W'(sweep_blk) + NEXT_W'(1)) : EMPTY_MARK;

    assign o_stat.clear_last = (r_sweep == '1);

    assign cnt_dec = r_rc_rd - REF_BITS'(1);
    assign cnt_inc = r_rc_rd + REF_BITS'(1);

    // Clearing pass writes the swept entry; write-back updates the entries read at accept and forms the result word.
    always_comb begin
        nf_we           = 1'b0;
        nf_wd           = sweep_link;
        rc_we           = 1'b0;
        rc_wd           = '0;
        head_we         = 1'b0;
        head_wd         = r_nf_rd;
        n_status        = ST_OK;
        n_granted_class = '0;
        n_granted_index = '0;
        n_ref_count     = '0;
        if (i_cmd.clear_en) begin
            nf_we = 1'b1;
            rc_we = 1'b1;
        end else if (i_cmd.exec) begin
            case (r_kind)
                REQ_ALLOC: begin
                    if (r_too_large) begin
                        n_status = ST_TOO_LARGE;
                    end else if (r_head >= EMPTY_MARK) begin
                        n_status        = ST_EMPTY;
                        n_granted_class = r_cls;
                    end else begin
                        n_granted_class = r_cls;
                        n_granted_index = IN_IDX_W'(r_head);
                        n_ref_count     = OUT_CNT_W'(1);
                        nf_we           = 1'b1;
                        nf_wd           = EMPTY_MARK;
                        rc_we           = 1'b1;
                        rc_wd           = REF_BITS'(1);
                        head_we         = 1'b1;
                        head_wd         = r_nf_rd;
                    end
                end
                REQ_FREE, REQ_ADDREF: begin
                    n_granted_class = r_cls;
                    n_granted_index = r_in_idx;
                    if (r_oob || (r_rc_rd == '0)) begin
                        n_status = ST_NOT_ALLOC;
                    end else if (r_kind == REQ_FREE) begin
                        rc_we       = 1'b1;
                        rc_wd       = cnt_dec;
                        n_ref_count = OUT_CNT_W'(cnt_dec);
                        if (cnt_dec == '0) begin
                            // Last reference gone: the block goes back on top of its list.
                            nf_we   = 1'b1;
                            nf_wd   = head_rd;
                            head_we = 1'b1;
                            head_wd = NEXT_W'(r_idx);
                        end
                    end else if (r_rc_rd == REF_MAX) begin
                        n_status    = ST_SATURATED;
                        n_ref_count = OUT_CNT_W'(r_rc_rd);
                    end else begin
                        rc_we       = 1'b1;
                        rc_wd       = cnt_inc;
                        n_ref_count = OUT_CNT_W'(cnt_inc);
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    assign mem_waddr = i_cmd.clear_en ? r_sweep : r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit[0] <= LIMIT0_RST;
            r_limit[1] <= LIMIT1_RST;
            r_limit[2] <= LIMIT2_RST;
            r_limit[3] <= LIMIT3_RST;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_free_head[c] <= '0;
            end
            r_sweep <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit[i_cfg_index] <= i_cfg_data;
            end
            if (head_we) begin
                r_free_head[r_cls] <= head_wd;
            end
            if (i_cmd.clear_en) begin
                r_sweep <= r_sweep + SLOT_W'(1);
            end
            r_done <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nf_we) begin
            r_next_free[mem_waddr] <= nf_wd;
        end
        if (rc_we) begin
            r_ref_counts[mem_waddr] <= rc_wd;
        end
        if (i_cmd.accept) begin
            r_nf_rd <= r_next_free[rd_addr];
            r_rc_rd <= r_ref_counts[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind      <= t_req'(i_req_type);
            r_cls       <= rd_cls;
            r_idx       <= in_blk;
            r_in_idx    <= i_block_index;
            r_oob       <= in_oob;
            r_too_large <= too_large;
            r_head      <= head_rd;
            r_slot      <= rd_addr;
        end
        if (i_cmd.exec) begin
            r_status        <= n_status;
            r_granted_class <= n_granted_class;
            r_granted_index <= n_granted_index;
            r_ref_count     <= n_ref_count;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_class = r_granted_class;
    assign o_granted_index = r_granted_index;
    assign o_ref_count     = r_ref_count;

endmodule

/* hdl/size_class_block_pool_allocator.sv */
// A request word accepted in the idle state has its link and count entries read at accept;
// the exec state then writes them back and registers its result word, marked by o_done, and
// the receiver cannot stall it. No new request word is taken until that write-back is done,
// since the write-back goes to the same entry of the link and count memories read at accept.
// Reset (synchronous, active low) starts a clearing pass over every entry (one entry of
// each memory a cycle) with o_busy high; configuration writes are taken throughout.
module size_class_block_pool_allocator
    import scbpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: one class limit per write, no read-back.
    input  logic                 i_cfg_we,
    input  logic [CLS_W-1:0]     i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    // Request word, taken when i_start is high and o_busy is low.
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_req_type,
    input  logic [SIZE_W-1:0]    i_request_size,
    input  logic [CLS_W-1:0]     i_block_class,
    input  logic [IN_IDX_W-1:0]  i_block_index,
    // Result word, valid for the single cycle in which o_done is high.
    output logic                 o_done,
    output logic [ST_W-1:0]      o_status,
    output logic [CLS_W-1:0]     o_granted_class,
    output logic [IN_IDX_W-1:0]  o_granted_index,
    output logic [OUT_CNT_W-1:0] o_ref_count
);

    // The controller sequences the clearing pass, the accept cycle and the
    // write-back cycle; the datapath holds the limits, the free-list heads and
    // the link and count memories.
    t_cmd  cmd;
    t_stat stat;

    scbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    scbpa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_request_size  (i_request_size),
        .i_block_class   (i_block_class),
        .i_block_index   (i_block_index),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_class (o_granted_class),
        .o_granted_index (o_granted_index),
        .o_ref_count     (o_ref_count)
    );

    // An accepted word is always followed by its write-back cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> cmd.exec)
        else $error("accepted word not followed by write-back");

    // Every write-back produces exactly one result strobe in the next cycle.
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> (o_done && !cmd.exec))
        else $error("write-back without result strobe");

    // The block is ready again in the cycle its result is shown.
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_busy && !cmd.clear_en))
        else $error("busy while result is shown");

    // A failed request never reports a live count, saturation aside.
    a_fail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_TOO_LARGE || o_status == ST_EMPTY ||
                    o_status == ST_NOT_ALLOC)) |-> (o_ref_count == '0))
        else $error("failed request reports nonzero count");

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scbpa_pkg::*;

    // The watchdog is far above the slowest legal run: about 670 request words,
    // each with its own work and a random sender gap, the clearing pass after
    // reset, and the writes of the class limits.
    localparam int CYCLE_LIMIT = 200000;

    // A result word arrives after the write-back that follows acceptance, so
    // SETTLE_CYCLES of quiet after the last result are enough to catch strays.
    localparam int SETTLE_CYCLES = 4;

    // Class limit registers, in the order of their write indexes.
    typedef enum logic [CLS_W-1:0] {
        CFG_LIMIT0 = 2'd0,
        CFG_LIMIT1 = 2'd1,
        CFG_LIMIT2 = 2'd2,
        CFG_LIMIT3 = 2'd3
    } t_cfg_reg;

    // How the random part shapes its request words.
    typedef enum int {
        MODE_MIX,
        MODE_FILL,
        MODE_HAMMER
    } t_mode;

    // One result word as the block reports it.
    typedef struct packed {
        t_status              status;
        logic [CLS_W-1:0]     cls;
        logic [IN_IDX_W-1:0]  idx;
        logic [OUT_CNT_W-1:0] cnt;
    } t_reply;

    // Mirror of the allocator: its own copy of the class limits, the free-list
    // heads, the links and the reference counts. Each accepted request word is
    // run against this copy to produce the result word the block must return,
    // and the replies come back in order since there is exactly one per request.
    class pool_mirror;
        logic [LIMIT_W-1:0]  limit [NUM_CLASSES];
        logic [NEXT_W-1:0]   head  [NUM_CLASSES];
        logic [NEXT_W-1:0]   link  [MEM_DEPTH];
        logic [REF_BITS-1:0] refs  [MEM_DEPTH];
        t_reply              replies_due[$];
        int                  errors;

        function new();
            int blk;
            limit[0] = LIMIT0_RST;
            limit[1] = LIMIT1_RST;
            limit[2] = LIMIT2_RST;
            limit[3] = LIMIT3_RST;
            foreach (head[c]) head[c] = '0;
            // Every class starts as one chain in index order, the last block
            // holding the empty mark.
            for (int s = 0; s < MEM_DEPTH; s++) begin
                blk = s % BLOCKS_PER_CLASS;
                link[s] = (blk + 1 < BLOCKS_PER_CLASS) ? NEXT_W'(blk + 1) : EMPTY_MARK;
                refs[s] = '0;
            end
            errors = 0;
        endfunction

        // Works out the reply to one request and updates the mirrored state.
        function void note_request(t_req kind, logic [SIZE_W-1:0] size,
                                   logic [CLS_W-1:0] cls, logic [IN_IDX_W-1:0] idx);
            t_reply              r;
            int                  c;
            int                  slot;
            logic [REF_BITS-1:0] cnt;
            r = '0;
            case (kind)
                REQ_ALLOC: begin
                    // First class whose limit covers the size wins, in class order.
                    c = 0;
                    while (c < NUM_CLASSES && size > SIZE_W'(limit[c])) c++;
                    if (c == NUM_CLASSES) begin
                        r.status = ST_TOO_LARGE;
                    end else if (head[c] == EMPTY_MARK) begin
                        r.status = ST_EMPTY;
                        r.cls    = CLS_W'(c);
                    end else begin
                        slot      = c * BLOCKS_PER_CLASS + int'(head[c]);
                        r.status  = ST_OK;
                        r.cls     = CLS_W'(c);
                        r.idx     = IN_IDX_W'(head[c]);
                        r.cnt     = OUT_CNT_W'(1);
                        head[c]   = link[slot];
                        link[slot] = EMPTY_MARK;
                        refs[slot] = REF_BITS'(1);
                    end
                end
                REQ_FREE, REQ_ADDREF: begin
                    r.cls = cls;
                    r.idx = idx;
                    slot  = int'(cls) * BLOCKS_PER_CLASS + int'(idx);
                    if (int'(idx) >= BLOCKS_PER_CLASS || refs[slot] == '0) begin
                        r.status = ST_NOT_ALLOC;
                    end else if (kind == REQ_FREE) begin
                        // A shared block only loses one reference; the last one
                        // puts it back on top of its class's free list.
                        cnt        = refs[slot] - 1'b1;
                        refs[slot] = cnt;
                        if (cnt == '0) begin
                            link[slot] = head[cls];
                            head[cls]  = NEXT_W'(idx);
                        end
                        r.status = ST_OK;
                        r.cnt    = OUT_CNT_W'(cnt);
                    end else if (refs[slot] == REF_MAX) begin
                        r.status = ST_SATURATED;
                        r.cnt    = OUT_CNT_W'(refs[slot]);
                    end else begin
                        cnt        = refs[slot] + 1'b1;
                        refs[slot] = cnt;
                        r.status   = ST_OK;
                        r.cnt      = OUT_CNT_W'(cnt);
                    end
                end
                default: begin
                    // An unknown request leaves everything alone and reports zeros.
                end
            endcase
            replies_due.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // Matches one result word against the oldest reply still owed.
        function void check_reply(t_reply got);
            t_reply want;
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: result word with no request outstanding, %s %0d/%0d/%0d/%0d",
                         $time, "expected none, got", got.status, got.cls, got.idx,
                         got.cnt);
                return;
            end
            want = replies_due.pop_front();
            compare_field("status", int'(want.status), int'(got.status));
            compare_field("granted_class", int'(want.cls), int'(got.cls));
            compare_field("granted_index", int'(want.idx), int'(got.idx));
            compare_field("ref_count", int'(want.cnt), int'(got.cnt));
        endfunction

        // Finds some block that currently holds a reference, starting the scan
        // at a random slot so that the choice spreads over all classes.
        function bit pick_live(output logic [CLS_W-1:0] cls, output logic [IN_IDX_W-1:0] idx);
            int start;
            int s;
            start = $urandom_range(0, MEM_DEPTH - 1);
            cls   = '0;
            idx   = '0;
            for (int k = 0; k < MEM_DEPTH; k++) begin
                s = (start + k) % MEM_DEPTH;
                if (refs[s] != '0) begin
                    cls = CLS_W'(s / BLOCKS_PER_CLASS);
                    idx = IN_IDX_W'(s % BLOCKS_PER_CLASS);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CLS_W-1:0]     i_cfg_index;
    logic [LIMIT_W-1:0]   i_cfg_data;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_req_type;
    logic [SIZE_W-1:0]    i_request_size;
    logic [CLS_W-1:0]     i_block_class;
    logic [IN_IDX_W-1:0]  i_block_index;
    logic                 o_done;
    logic [ST_W-1:0]      o_status;
    logic [CLS_W-1:0]     o_granted_class;
    logic [IN_IDX_W-1:0]  o_granted_index;
    logic [OUT_CNT_W-1:0] o_ref_count;

    size_class_block_pool_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_req_type      (i_req_type),
        .i_request_size  (i_request_size),
        .i_block_class   (i_block_class),
        .i_block_index   (i_block_index),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_class (o_granted_class),
        .o_granted_index (o_granted_index),
        .o_ref_count     (o_ref_count)
    );

    pool_mirror            mirror = new();
    int                    burst_left = 0;
    int                    cycles = 0;
    logic [CLS_W-1:0]      hammer_cls = '0;
    logic [IN_IDX_W-1:0]   hammer_idx = '0;
    t_reply                seen;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a run that stalls anywhere ends here as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result monitor. Outputs are sampled at the rising edge, before the block's
    // own updates for that edge land, so the word seen is the one that edge takes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            seen.status = t_status'(o_status);
            seen.cls    = o_granted_class;
            seen.idx    = o_granted_index;
            seen.cnt    = o_ref_count;
            mirror.check_reply(seen);
        end
    end

    // Presents one request word and holds it until the block takes it. The
    // sender runs in bursts; at the start of each new burst it drops start for
    // a random gap, so the gaps land at every point of the block's accept and write-back.
    task automatic send_word(input t_req kind, input logic [SIZE_W-1:0] size,
                             input logic [CLS_W-1:0] cls, input logic [IN_IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            // Now and then a long burst keeps the block loaded back to back.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        @(negedge i_clk);
        i_start        = 1'b1;
        i_req_type     = kind;
        i_request_size = size;
        i_block_class  = cls;
        i_block_index  = idx;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        mirror.note_request(kind, size, cls, idx);
        burst_left--;
    endtask

    // Waits until every owed result word has come back, with start held low.
    task automatic wait_idle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (mirror.replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input t_cfg_reg r, input logic [LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = r;
        i_cfg_data  = value;
        mirror.limit[int'(r)] = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_limits(input logic [LIMIT_W-1:0] l0, input logic [LIMIT_W-1:0] l1,
                                input logic [LIMIT_W-1:0] l2, input logic [LIMIT_W-1:0] l3);
        write_limit(CFG_LIMIT0, l0);
        write_limit(CFG_LIMIT1, l1);
        write_limit(CFG_LIMIT2, l2);
        write_limit(CFG_LIMIT3, l3);
    endtask

    // Sizes cluster on the class boundaries, with some small and some wild values.
    function automatic logic [SIZE_W-1:0] pick_size();
        logic [SIZE_W-1:0] lim;
        lim = SIZE_W'(mirror.limit[$urandom_range(0, NUM_CLASSES - 1)]);
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return '0;
            2: return '1;
            3, 4: return lim;
            5: return lim + 1'b1;
            default: return $urandom_range(0, 2048);
        endcase
    endfunction

    // One random request word. Fill mode drives nearly all allocations into the
    // class that takes every 16-bit size, so that class runs dry. Hammer mode
    // piles references onto one block until its count saturates. Mix mode works
    // mostly on live handles, with some requests against random handles.
    task automatic random_word(input t_mode mode);
        int                  p;
        bit                  live;
        logic [CLS_W-1:0]    c;
        logic [IN_IDX_W-1:0] x;
        p    = $urandom_range(0, 99);
        live = mirror.pick_live(c, x);
        if (mode == MODE_HAMMER && p < 97) begin
            send_word(REQ_ADDREF, $urandom, hammer_cls, hammer_idx);
        end else if (mode == MODE_FILL && p < 95) begin
            send_word(REQ_ALLOC, $urandom_range(0, 65535), CLS_W'($urandom),
                      IN_IDX_W'($urandom));
        end else if (mode == MODE_FILL && p < 98 && live) begin
            send_word(REQ_FREE, $urandom, c, x);
        end else begin
            p = $urandom_range(0, 99);
            if (p < 40) begin
                send_word(REQ_ALLOC, pick_size(), CLS_W'($urandom), IN_IDX_W'($urandom));
            end else if (p < 65 && live) begin
                send_word(REQ_FREE, $urandom, c, x);
            end else if (p < 85 && live) begin
                send_word(REQ_ADDREF, $urandom, c, x);
            end else if (p < 95) begin
                // A random handle is most likely a block that was never handed out.
                send_word(($urandom_range(0, 1) == 0) ? REQ_FREE : REQ_ADDREF,
                          $urandom, CLS_W'($urandom), IN_IDX_W'($urandom));
            end else begin
                send_word(REQ_NONE, $urandom, CLS_W'($urandom), IN_IDX_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_start        = 1'b0;
        i_req_type     = REQ_NONE;
        i_request_size = '0;
        i_block_class  = '0;
        i_block_index  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with the reset limits 64/128/512/1024. The first word
        // waits out the clearing pass that follows reset.
        send_word(REQ_ALLOC, 32'd0, '0, '0);
        send_word(REQ_ALLOC, 32'd64, '0, '0);
        send_word(REQ_ALLOC, 32'd65, '0, '0);
        send_word(REQ_ALLOC, 32'd128, '0, '0);
        send_word(REQ_ALLOC, 32'd129, '0, '0);
        send_word(REQ_ALLOC, 32'd512, '0, '0);
        send_word(REQ_ALLOC, 32'd513, '0, '0);
        send_word(REQ_ALLOC, 32'd1024, '0, '0);
        // Sizes no class covers.
        send_word(REQ_ALLOC, 32'd1025, '0, '0);
        send_word(REQ_ALLOC, 32'hFFFF_FFFF, 2'd3, 8'hFF);
        // A shared block: the first free only drops a reference, the second
        // returns it, and the next allocation gets the same block back.
        send_word(REQ_ADDREF, '0, 2'd0, 8'd0);
        send_word(REQ_FREE, '0, 2'd0, 8'd0);
        send_word(REQ_FREE, '0, 2'd0, 8'd0);
        send_word(REQ_ALLOC, 32'd1, '0, '0);
        // Handles that were never allocated.
        send_word(REQ_FREE, '1, 2'd3, 8'hFF);
        send_word(REQ_ADDREF, '0, 2'd2, 8'hFF);
        // A double free.
        send_word(REQ_FREE, '0, 2'd0, 8'd1);
        send_word(REQ_FREE, '0, 2'd0, 8'd1);
        // Unknown request type, with all-ones and all-zeros fields.
        send_word(REQ_NONE, '1, 2'd3, 8'hFF);
        send_word(REQ_NONE, '0, 2'd0, 8'd0);
        send_word(REQ_ADDREF, '0, 2'd3, 8'd1);
        send_word(REQ_FREE, '0, 2'd3, 8'd0);

        // Limits out of order: size 0 goes to class 0, size 1 to class 1,
        // everything else up to 16 bits to class 2, and class 3 serves nothing new.
        wait_idle();
        write_limits(16'd0, 16'd1, 16'hFFFF, 16'd0);
        repeat (40) random_word(MODE_MIX);

        // Class 0 takes every 16-bit size; allocate until its pool is empty.
        wait_idle();
        write_limits(16'hFFFF, LIMIT_W'($urandom), LIMIT_W'($urandom), LIMIT_W'($urandom));
        repeat (290) random_word(MODE_FILL);

        // Drive one live block to the top of its reference count.
        wait_idle();
        write_limits(LIMIT_W'($urandom), LIMIT_W'($urandom), LIMIT_W'($urandom),
                     LIMIT_W'($urandom));
        void'(mirror.pick_live(hammer_cls, hammer_idx));
        repeat (275) random_word(MODE_HAMMER);

        // Back to a general mix; frees now refill the lists in LIFO order.
        wait_idle();
        write_limits(LIMIT_W'($urandom), LIMIT_W'($urandom), LIMIT_W'($urandom), 16'hFFFF);
        repeat (40) random_word(MODE_MIX);

        wait_idle();
        if (mirror.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/scbpa_pkg.sv
hdl/scbpa_ctrl.sv
hdl/scbpa_dp.sv
hdl/size_class_block_pool_allocator.sv
tb/sv/tb_top.sv
